// File: rtl/core/snfcs_pkg.sv
// Shared types and constants for the serial NOR flash command sequencer.
`timescale 1ns / 1ps

package snfcs_pkg;

    // Program page size; a power of two so the page offset is a plain mask
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_LOG   = $clog2(PAGE_BYTES);

    // Host request codes
    localparam logic [2:0] OP_READ_ID = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_PROGRAM = 3'd2;
    localparam logic [2:0] OP_ERASE   = 3'd3;
    localparam logic [2:0] OP_REPLY   = 3'd4;

    // Flash command bytes
    localparam logic [7:0] CMD_READ_ID = 8'h9F;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_RDSR    = 8'h05;
    localparam logic [7:0] CMD_SE      = 8'h20;
    localparam logic [7:0] CMD_PP      = 8'h02;
    localparam logic [7:0] CMD_READ    = 8'h03;
    localparam logic [7:0] SR_WIP      = 8'h01;
    localparam logic [7:0] DUMMY       = 8'h00;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_READ = 3'd2;
    localparam logic [2:0] PH_PROG = 3'd3;
    localparam logic [2:0] PH_POLL = 3'd4;

    // Kind of result sequence that one input word starts
    localparam logic [3:0] K_REJ       = 4'd0;
    localparam logic [3:0] K_ID        = 4'd1;
    localparam logic [3:0] K_READ      = 4'd2;
    localparam logic [3:0] K_PROG_NEW  = 4'd3;
    localparam logic [3:0] K_ERASE     = 4'd4;
    localparam logic [3:0] K_REPLY     = 4'd5;
    localparam logic [3:0] K_PROG_BYTE = 4'd6;
    localparam logic [3:0] K_PROG_BND  = 4'd7;
    localparam logic [3:0] K_POLL_BUSY = 4'd8;
    localparam logic [3:0] K_POLL_RES  = 4'd9;
    localparam logic [3:0] K_POLL_DONE = 4'd10;

    // Positions in the shared write-enable / program / poll frame
    localparam logic [3:0] FP_RELEASE = 4'd0;
    localparam logic [3:0] FP_WREN    = 4'd1;
    localparam logic [3:0] FP_CMD     = 4'd2;
    localparam logic [3:0] FP_ADDR_H  = 4'd3;
    localparam logic [3:0] FP_ADDR_M  = 4'd4;
    localparam logic [3:0] FP_ADDR_L  = 4'd5;
    localparam logic [3:0] FP_DATA    = 4'd6;
    localparam logic [3:0] FP_RDSR    = 4'd7;
    localparam logic [3:0] FP_DUMMY   = 4'd8;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       byte_valid;
        logic       end_frame;
        logic       expect_reply;
        logic [7:0] host_byte;
        logic       host_valid;
        logic       done_res;
        logic       rejected;
        logic       last;
    } res_t;

endpackage

// File: rtl/core/spi_nor_flash_command_sequencer.sv
// Top level of the serial NOR flash command sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   in      | to block  | in_valid/in_stall  | operation, address, read_count, data_byte,
//           |           |                    | data_last
//   out     | from block| out_valid/out_stall| spi_byte, byte_valid, end_frame, expect_reply,
//           |           |                    | host_byte, host_valid, done_res, rejected, last
//
// One result word leaves per cycle unless out stalls; an input word yields 1 to 9 results,
// all through the single result register. The next input word is taken in the cycle
// its predecessor's last result is loaded. Reset (rst_n low) empties both registers and
// returns to idle. A stall on out holds the result register and, through it, the input.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer
    import snfcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [23:0] address,
    input  logic [15:0] read_count,
    input  logic [7:0]  data_byte,
    input  logic        data_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  spi_byte,
    output logic        byte_valid,
    output logic        end_frame,
    output logic        expect_reply,
    output logic [7:0]  host_byte,
    output logic        host_valid,
    output logic        done_res,
    output logic        rejected,
    output logic        last
);

    // Input word register
    logic        item_valid_reg;
    logic [2:0]  item_op_reg;
    logic [23:0] item_addr_reg;
    logic [15:0] item_count_reg;
    logic [7:0]  item_data_reg;
    logic        item_last_reg;

    // Architectural state
    logic [2:0]  phase_reg, phase_next;
    logic [23:0] ap_reg, ap_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [1:0]  id_left_reg, id_left_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_last_reg, held_last_next;
    logic        held_valid_reg, held_valid_next;

    // Sequencer
    logic [3:0]  step_reg;
    logic [3:0]  kind;
    logic [3:0]  pos;
    logic [3:0]  last_pos;
    logic        fin;
    logic [23:0] frame_addr;
    logic [7:0]  frame_data;
    logic [15:0] cur_left;
    logic [15:0] left_dec;
    logic        emit;
    logic        seq_last;
    res_t        res;

    // Result register
    logic        out_valid_reg;
    res_t        out_reg;

    assign emit     = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !(emit && seq_last);

    // Decide what the held word means in the current phase
    always_comb
    begin
        kind = K_REJ;
        case (phase_reg)
            PH_IDLE:
            begin
                case (item_op_reg)
                    OP_READ_ID: kind = K_ID;
                    OP_READ:    kind = K_READ;
                    OP_PROGRAM: kind = K_PROG_NEW;
                    OP_ERASE:   kind = K_ERASE;
                    default:    kind = K_REJ;
                endcase
            end
            PH_ID, PH_READ:
            begin
                if (item_op_reg == OP_REPLY)
                    kind = K_REPLY;
            end
            PH_PROG:
            begin
                if (item_op_reg == OP_PROGRAM)
                    kind = (ap_reg[PAGE_LOG-1:0] == '0) ? K_PROG_BND : K_PROG_BYTE;
            end
            PH_POLL:
            begin
                if (item_op_reg == OP_REPLY)
                begin
                    if (item_data_reg[0])
                        kind = K_POLL_BUSY;
                    else if (held_valid_reg)
                        kind = K_POLL_RES;
                    else
                        kind = K_POLL_DONE;
                end
            end
            default: kind = K_REJ;
        endcase
    end

    // Map the step onto the shared frame position
    always_comb
    begin
        case (kind)
            K_PROG_NEW:  pos = step_reg + 4'd1;
            K_POLL_RES:  pos = step_reg;
            K_PROG_BYTE: pos = step_reg + 4'd6;
            K_PROG_BND:  pos = (step_reg == 4'd0) ? FP_RELEASE : step_reg + 4'd6;
            K_ERASE:     pos = (step_reg < 4'd5) ? step_reg + 4'd1 : step_reg + 4'd2;
            default:     pos = step_reg;
        endcase
    end

    assign fin        = (kind == K_POLL_RES) ? held_last_reg : item_last_reg;
    assign frame_addr = (kind == K_POLL_RES) ? ap_reg : item_addr_reg;
    assign frame_data = (kind == K_POLL_RES) ? held_byte_reg : item_data_reg;
    assign last_pos   = (kind == K_PROG_BND || kind == K_ERASE || fin) ? FP_DUMMY : FP_DATA;
    assign cur_left   = (phase_reg == PH_ID) ? {14'd0, id_left_reg} : bytes_left_reg;
    assign left_dec   = (cur_left == '0) ? '0 : cur_left - 16'd1;

    // Build the result for the current step
    always_comb
    begin
        res      = '0;
        seq_last = 1'b1;
        case (kind)
            K_ID:
            begin
                res.byte_valid = 1'b1;
                if (step_reg == 4'd0)
                begin
                    res.spi_byte = CMD_READ_ID;
                    seq_last     = 1'b0;
                end
                else
                begin
                    res.spi_byte     = DUMMY;
                    res.expect_reply = 1'b1;
                end
            end
            K_READ:
            begin
                res.byte_valid = 1'b1;
                seq_last       = 1'b0;
                case (step_reg)
                    4'd0: res.spi_byte = CMD_READ;
                    4'd1: res.spi_byte = item_addr_reg[23:16];
                    4'd2: res.spi_byte = item_addr_reg[15:8];
                    4'd3:
                    begin
                        res.spi_byte  = item_addr_reg[7:0];
                        res.end_frame = (item_count_reg == '0);
                        res.done_res  = (item_count_reg == '0);
                        seq_last      = (item_count_reg == '0);
                    end
                    default:
                    begin
                        res.spi_byte     = DUMMY;
                        res.expect_reply = 1'b1;
                        res.end_frame    = (item_count_reg == 16'd1);
                        seq_last         = 1'b1;
                    end
                endcase
            end
            K_PROG_NEW, K_ERASE, K_PROG_BYTE, K_PROG_BND, K_POLL_RES:
            begin
                seq_last       = (pos == last_pos);
                res.byte_valid = 1'b1;
                case (pos)
                    FP_RELEASE:
                    begin
                        res.byte_valid = 1'b0;
                        res.end_frame  = 1'b1;
                    end
                    FP_WREN:
                    begin
                        res.spi_byte  = CMD_WREN;
                        res.end_frame = 1'b1;
                    end
                    FP_CMD:    res.spi_byte = (kind == K_ERASE) ? CMD_SE : CMD_PP;
                    FP_ADDR_H: res.spi_byte = frame_addr[23:16];
                    FP_ADDR_M: res.spi_byte = frame_addr[15:8];
                    FP_ADDR_L:
                    begin
                        res.spi_byte  = frame_addr[7:0];
                        res.end_frame = (kind == K_ERASE);
                    end
                    FP_DATA:
                    begin
                        res.spi_byte  = frame_data;
                        res.end_frame = fin;
                    end
                    FP_RDSR:   res.spi_byte = CMD_RDSR;
                    default:
                    begin
                        res.spi_byte     = DUMMY;
                        res.expect_reply = 1'b1;
                    end
                endcase
            end
            K_REPLY:
            begin
                res.host_byte  = item_data_reg;
                res.host_valid = 1'b1;
                if (left_dec != '0)
                begin
                    res.byte_valid   = 1'b1;
                    res.spi_byte     = DUMMY;
                    res.expect_reply = 1'b1;
                    res.end_frame    = (left_dec == 16'd1);
                end
                else
                begin
                    res.done_res = 1'b1;
                end
            end
            K_POLL_BUSY:
            begin
                res.byte_valid   = 1'b1;
                res.spi_byte     = DUMMY;
                res.expect_reply = 1'b1;
            end
            K_POLL_DONE:
            begin
                res.end_frame = 1'b1;
                res.done_res  = 1'b1;
            end
            default:
            begin
                res.rejected = 1'b1;
            end
        endcase
        res.last = seq_last;
    end

    // State effect of a finished word
    always_comb
    begin
        phase_next      = phase_reg;
        ap_next         = ap_reg;
        bytes_left_next = bytes_left_reg;
        id_left_next    = id_left_reg;
        held_byte_next  = held_byte_reg;
        held_last_next  = held_last_reg;
        held_valid_next = held_valid_reg;
        case (kind)
            K_ID:
            begin
                id_left_next = 2'd3;
                phase_next   = PH_ID;
            end
            K_READ:
            begin
                if (item_count_reg != '0)
                begin
                    bytes_left_next = item_count_reg;
                    phase_next      = PH_READ;
                end
            end
            K_PROG_NEW, K_PROG_BYTE, K_POLL_RES:
            begin
                ap_next         = ((kind == K_PROG_NEW) ? item_addr_reg : ap_reg) + 24'd1;
                held_valid_next = (kind == K_PROG_BYTE) ? held_valid_reg : 1'b0;
                phase_next      = fin ? PH_POLL : PH_PROG;
            end
            K_ERASE:
            begin
                held_valid_next = 1'b0;
                phase_next      = PH_POLL;
            end
            K_REPLY:
            begin
                if (phase_reg == PH_ID)
                    id_left_next = left_dec[1:0];
                else
                    bytes_left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_IDLE;
            end
            K_PROG_BND:
            begin
                held_byte_next  = item_data_reg;
                held_last_next  = item_last_reg;
                held_valid_next = 1'b1;
                phase_next      = PH_POLL;
            end
            K_POLL_DONE: phase_next = PH_IDLE;
            default:     phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
            phase_reg      <= PH_IDLE;
            ap_reg         <= '0;
            bytes_left_reg <= '0;
            id_left_reg    <= '0;
            held_last_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                item_valid_reg <= 1'b1;
            else if (emit && seq_last)
                item_valid_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (emit)
            begin
                if (seq_last)
                begin
                    // Commit state and drop the word
                    step_reg       <= '0;
                    phase_reg      <= phase_next;
                    ap_reg         <= ap_next;
                    bytes_left_reg <= bytes_left_next;
                    id_left_reg    <= id_left_next;
                    held_last_reg  <= held_last_next;
                    held_valid_reg <= held_valid_next;
                end
                else
                begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_op_reg    <= operation;
            item_addr_reg  <= address;
            item_count_reg <= read_count;
            item_data_reg  <= data_byte;
            item_last_reg  <= data_last;
        end
        if (emit)
            out_reg <= res;
        if (emit && seq_last)
            held_byte_reg <= held_byte_next;
    end

    assign out_valid    = out_valid_reg;
    assign spi_byte     = out_reg.spi_byte;
    assign byte_valid   = out_reg.byte_valid;
    assign end_frame    = out_reg.end_frame;
    assign expect_reply = out_reg.expect_reply;
    assign host_byte    = out_reg.host_byte;
    assign host_valid   = out_reg.host_valid;
    assign done_res     = out_reg.done_res;
    assign rejected     = out_reg.rejected;
    assign last         = out_reg.last;

endmodule

// File: rtl/core/snfcs_checker.sv
// Port-level checks for the serial NOR flash command sequencer, bound to the top level.
`timescale 1ns / 1ps

module snfcs_checker
    import snfcs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] spi_byte,
    input logic       byte_valid,
    input logic       end_frame,
    input logic       expect_reply,
    input logic [7:0] host_byte,
    input logic       host_valid,
    input logic       done_res,
    input logic       rejected,
    input logic       last
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(spi_byte) && $stable(last)
            && $stable(host_byte) && $stable(done_res) && $stable(rejected))
        else $error("result word changed under stall");

    // A refusal carries nothing else and closes the word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last && !byte_valid && !end_frame && !expect_reply
            && !host_valid && !done_res && spi_byte == 8'h00 && host_byte == 8'h00)
        else $error("rejected result not clean");

    // Completion and reply waits always end the word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_res || expect_reply) |-> last)
        else $error("done or reply wait not on last result");

    // A reply wait is always a dummy byte on the wire
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expect_reply |-> byte_valid && spi_byte == DUMMY && !done_res)
        else $error("reply wait without dummy byte");

    // Unused byte lanes read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || spi_byte == 8'h00) && (host_valid || host_byte == 8'h00))
        else $error("unused byte lane not zero");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .spi_byte     (spi_byte),
    .byte_valid   (byte_valid),
    .end_frame    (end_frame),
    .expect_reply (expect_reply),
    .host_byte    (host_byte),
    .host_valid   (host_valid),
    .done_res     (done_res),
    .rejected     (rejected),
    .last         (last)
);

// File: sim/spi_nor_flash_command_sequencer_tb.sv
// Self-checking testbench for the serial NOR flash command sequencer.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_tb;
    import snfcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          PRINT_LIMIT = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic [23:0] address = '0;
    logic [15:0] read_count = '0;
    logic [7:0]  data_byte = '0;
    logic        data_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  spi_byte;
    logic        byte_valid;
    logic        end_frame;
    logic        expect_reply;
    logic [7:0]  host_byte;
    logic        host_valid;
    logic        done_res;
    logic        rejected;
    logic        last;

    // Sequencer state as the checker sees it
    logic [2:0]  flash_phase = PH_IDLE;
    logic [23:0] prog_ptr = '0;
    logic [15:0] read_left = '0;
    logic [1:0]  id_left = '0;
    logic [7:0]  held_byte = '0;
    logic        held_last = 1'b0;
    logic        held_valid = 1'b0;

    res_t        expected_words[$];
    res_t        pend[10];
    int          n_pend;
    int          errors = 0;
    int          n_checked = 0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;

    spi_nor_flash_command_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .address      (address),
        .read_count   (read_count),
        .data_byte    (data_byte),
        .data_last    (data_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .spi_byte     (spi_byte),
        .byte_valid   (byte_valid),
        .end_frame    (end_frame),
        .expect_reply (expect_reply),
        .host_byte    (host_byte),
        .host_valid   (host_valid),
        .done_res     (done_res),
        .rejected     (rejected),
        .last         (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 13);
    end

    // ---------------- expected result words ----------------

    task automatic put_word(input logic [7:0] spi, input logic bv, input logic ef,
                            input logic er, input logic [7:0] hb, input logic hv,
                            input logic dn, input logic rj);
        res_t w;
        w.spi_byte     = spi;
        w.byte_valid   = bv;
        w.end_frame    = ef;
        w.expect_reply = er;
        w.host_byte    = hb;
        w.host_valid   = hv;
        w.done_res     = dn;
        w.rejected     = rj;
        w.last         = 1'b0;
        pend[n_pend] = w;
        n_pend++;
    endtask

    task automatic put_cmd(input logic [7:0] b, input logic ef);
        put_word(b, 1'b1, ef, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic put_addr(input logic [23:0] a, input logic ef);
        put_cmd(a[23:16], 1'b0);
        put_cmd(a[15:8], 1'b0);
        put_cmd(a[7:0], ef);
    endtask

    task automatic begin_poll();
        put_cmd(CMD_RDSR, 1'b0);
        put_word(DUMMY, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
        flash_phase = PH_POLL;
    endtask

    task automatic open_page();
        put_cmd(CMD_WREN, 1'b1);
        put_cmd(CMD_PP, 1'b0);
        put_addr(prog_ptr, 1'b0);
    endtask

    task automatic program_data(input logic [7:0] b, input logic fin);
        put_cmd(b, fin);
        prog_ptr = prog_ptr + 24'd1;
        if (fin)
            begin_poll();
        else
            flash_phase = PH_PROG;
    endtask

    // Work out the result words of one accepted input word and queue them
    task automatic predict_flash(input logic [2:0] op, input logic [23:0] a,
                                 input logic [15:0] cnt, input logic [7:0] d,
                                 input logic dl);
        logic        ok;
        logic [15:0] remaining;
        res_t        w;
        ok = 1'b1;
        n_pend = 0;
        case (flash_phase)
            PH_IDLE:
            begin
                if (op == OP_READ_ID)
                begin
                    put_cmd(CMD_READ_ID, 1'b0);
                    put_word(DUMMY, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
                    id_left = 2'd3;
                    flash_phase = PH_ID;
                end
                else if (op == OP_READ)
                begin
                    put_cmd(CMD_READ, 1'b0);
                    if (cnt == 16'd0)
                    begin
                        // empty read: frame and request both end on the last address byte
                        put_cmd(a[23:16], 1'b0);
                        put_cmd(a[15:8], 1'b0);
                        put_word(a[7:0], 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        put_addr(a, 1'b0);
                        put_word(DUMMY, 1'b1, cnt == 16'd1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
                        read_left = cnt;
                        flash_phase = PH_READ;
                    end
                end
                else if (op == OP_PROGRAM)
                begin
                    prog_ptr = a;
                    held_valid = 1'b0;
                    open_page();
                    program_data(d, dl);
                end
                else if (op == OP_ERASE)
                begin
                    put_cmd(CMD_WREN, 1'b1);
                    put_cmd(CMD_SE, 1'b0);
                    put_addr(a, 1'b1);
                    held_valid = 1'b0;
                    begin_poll();
                end
                else
                    ok = 1'b0;
            end
            PH_ID, PH_READ:
            begin
                if (op == OP_REPLY)
                begin
                    remaining = (flash_phase == PH_ID) ? {14'd0, id_left} : read_left;
                    if (remaining != 16'd0)
                        remaining = remaining - 16'd1;
                    if (flash_phase == PH_ID)
                        id_left = remaining[1:0];
                    else
                        read_left = remaining;
                    if (remaining != 16'd0)
                        put_word(DUMMY, 1'b1, remaining == 16'd1, 1'b1, d, 1'b1, 1'b0, 1'b0);
                    else
                    begin
                        put_word(8'h00, 1'b0, 1'b0, 1'b0, d, 1'b1, 1'b1, 1'b0);
                        flash_phase = PH_IDLE;
                    end
                end
                else
                    ok = 1'b0;
            end
            PH_PROG:
            begin
                if (op != OP_PROGRAM)
                    ok = 1'b0;
                else if ((prog_ptr % PAGE_BYTES) == 0)
                begin
                    // page full: release, poll, and hold the word for the next page
                    put_word(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
                    held_byte = d;
                    held_last = dl;
                    held_valid = 1'b1;
                    begin_poll();
                end
                else
                    program_data(d, dl);
            end
            PH_POLL:
            begin
                if (op != OP_REPLY)
                    ok = 1'b0;
                else if ((d & SR_WIP) != 8'h00)
                    put_word(DUMMY, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
                else if (held_valid)
                begin
                    put_word(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
                    held_valid = 1'b0;
                    open_page();
                    program_data(held_byte, held_last);
                end
                else
                begin
                    put_word(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
                    flash_phase = PH_IDLE;
                end
            end
            default:
                ok = 1'b0;
        endcase
        if (!ok)
        begin
            n_pend = 0;
            put_word(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        for (int i = 0; i < n_pend; i++)
        begin
            w = pend[i];
            w.last = (i == n_pend - 1);
            expected_words.push_back(w);
        end
    endtask

    // ---------------- driving and checking ----------------

    // Entered and left at a falling edge
    task automatic send_item(input logic [2:0] op, input logic [23:0] a,
                             input logic [15:0] cnt, input logic [7:0] d,
                             input logic dl);
        if (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= a;
        read_count <= cnt;
        data_byte  <= d;
        data_last  <= dl;
        do
            @(posedge clk);
        while (in_stall);
        predict_flash(op, a, cnt, d, dl);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_reply(input logic [7:0] d);
        send_item(OP_REPLY, 24'($urandom), 16'($urandom), d, 1'($urandom));
    endtask

    task automatic send_noise();
        send_item(3'($urandom_range(0, 7)), 24'($urandom), 16'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
        errors++;
    endtask

    task automatic check_result();
        res_t want;
        n_checked++;
        if (expected_words.size() == 0)
        begin
            report_mismatch("result with nothing pending", 1, 0);
            return;
        end
        want = expected_words.pop_front();
        if (spi_byte !== want.spi_byte)
            report_mismatch("spi_byte", spi_byte, want.spi_byte);
        if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", byte_valid, want.byte_valid);
        if (end_frame !== want.end_frame)
            report_mismatch("end_frame", end_frame, want.end_frame);
        if (expect_reply !== want.expect_reply)
            report_mismatch("expect_reply", expect_reply, want.expect_reply);
        if (host_byte !== want.host_byte)
            report_mismatch("host_byte", host_byte, want.host_byte);
        if (host_valid !== want.host_valid)
            report_mismatch("host_valid", host_valid, want.host_valid);
        if (done_res !== want.done_res)
            report_mismatch("done_res", done_res, want.done_res);
        if (rejected !== want.rejected)
            report_mismatch("rejected", rejected, want.rejected);
        if (last !== want.last)
            report_mismatch("last", last, want.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_result();
    end

    // Feed replies and final bytes until the sequencer is idle again
    task automatic finish_request();
        while (flash_phase != PH_IDLE)
        begin
            if ($urandom_range(24) == 0)
                send_noise();
            else if (flash_phase == PH_PROG)
                send_item(OP_PROGRAM, 24'($urandom), 16'($urandom), 8'($urandom), 1'b1);
            else
                send_reply(8'($urandom));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_read_id();
        send_item(OP_READ_ID, 24'h000000, 16'h0000, 8'h00, 1'b0);
        // busy: a new request must bounce
        send_item(OP_READ, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_reply(8'h00);
        send_reply(8'hFF);
        send_reply(8'hA5);
    endtask

    task automatic test_short_reads();
        send_item(OP_READ, 24'h000000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_READ, 24'hFFFFFF, 16'h0001, 8'hFF, 1'b1);
        send_reply(8'h5A);
    endtask

    task automatic test_unaligned_erase();
        send_item(OP_ERASE, 24'h012345, 16'h0000, 8'h00, 1'b0);
        send_item(OP_PROGRAM, 24'h000100, 16'h0000, 8'h11, 1'b1);
        send_reply(8'hFF);
        send_reply(8'h01);
        send_reply(8'hFE);
    endtask

    task automatic test_page_wrap();
        send_item(OP_PROGRAM, 24'hFFFFFE, 16'h0000, 8'h00, 1'b0);
        send_item(OP_PROGRAM, 24'h000000, 16'h0000, 8'hFF, 1'b0);
        send_item(OP_ERASE, 24'h000000, 16'h0000, 8'h00, 1'b0);
        send_reply(8'h00);
        // pointer has wrapped to zero: this word crosses into a new page
        send_item(OP_PROGRAM, 24'h123456, 16'h0000, 8'h80, 1'b1);
        send_reply(8'h00);
        send_reply(8'h00);
    endtask

    task automatic test_bad_items();
        send_reply(8'h3C);
        for (int op = 5; op <= 7; op++)
            send_item(3'(op), 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic test_random_traffic();
        int          start;
        int          kind;
        int          n;
        logic [23:0] a;
        logic [15:0] cnt;
        start = items_sent;
        while (items_sent - start < 150)
        begin
            // hold both sides busy through the middle stretch
            calm = (items_sent - start >= 60) && (items_sent - start < 110);
            kind = $urandom_range(99);
            a = 24'($urandom);
            if (kind < 15)
                send_item(OP_READ_ID, a, 16'($urandom), 8'($urandom), 1'($urandom));
            else if (kind < 35)
            begin
                cnt = ($urandom_range(7) == 0) ? 16'($urandom_range(7, 40))
                                               : 16'($urandom_range(0, 6));
                send_item(OP_READ, a, cnt, 8'($urandom), 1'($urandom));
            end
            else if (kind < 50)
                send_item(OP_ERASE, a, 16'($urandom), 8'($urandom), 1'($urandom));
            else if (kind < 90)
            begin
                n = ($urandom_range(19) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 12);
                if ($urandom_range(1) == 1)
                    a[7:0] = 8'hF8 | 8'($urandom_range(0, 7));
                for (int i = 0; i < n; i++)
                begin
                    while (flash_phase == PH_POLL)
                        send_reply(8'($urandom));
                    send_item(OP_PROGRAM, (i == 0) ? a : 24'($urandom), 16'($urandom),
                              8'($urandom), i == n - 1);
                    if ($urandom_range(24) == 0)
                        send_noise();
                end
            end
            else
                send_noise();
            finish_request();
        end
        calm = 1'b0;
    endtask

    task automatic test_longest_read();
        send_item(OP_READ, 24'($urandom), 16'hFFFF, 8'($urandom), 1'($urandom));
        // a few bytes of the full-count read; the request stays open to the end
        repeat (6)
            send_reply(8'($urandom));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_read_id();
        test_short_reads();
        test_unaligned_erase();
        test_page_wrap();
        test_bad_items();
        test_random_traffic();
        test_longest_read();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: spi_nor_flash_command_sequencer.f
rtl/core/snfcs_pkg.sv
rtl/core/spi_nor_flash_command_sequencer.sv
rtl/core/snfcs_checker.sv
sim/spi_nor_flash_command_sequencer_tb.sv
